// File: sv/brd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and codes for the bootloader reply deframer: beat payload
// structs, header byte codes and reply status codes.
// ----------------------------------------------------------------------------
package brd_pkg;

  // reply header codes
  localparam logic [7:0] HDR_DATA  = 8'h80;
  localparam logic [7:0] HDR_ACK   = 8'h90;
  localparam logic [7:0] HDR_NAK   = 8'hA0;
  localparam logic [7:0] FOLD_INIT = 8'hFF;

  // bytes of a data frame beyond its payload
  localparam int unsigned FRAME_EXTRA = 6;
  // position of the length byte and of the first payload byte
  localparam int unsigned LEN_POS     = 2;
  localparam int unsigned PAYLOAD_POS = 4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // reply status codes
  localparam logic [2:0] ST_ACK      = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_NAK      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_CKSUM    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic [2:0] status;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/brd_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brd_parse
// Reply frame state and per-byte decode: classifies the first byte, tracks
// position, length and the two XOR folds, and forms the result of a byte.
// State advances when the byte is consumed.
// ----------------------------------------------------------------------------
module brd_parse #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire brd_pkg::in_item_t  item,
  input  wire logic               fire,
  output logic                    has_result,
  output brd_pkg::out_item_t      result
);

  localparam int unsigned CW   = $clog2(BUFFER_BYTES) + 1;
  localparam int unsigned CMPW = (CW > 9) ? CW : 9;

  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    xe_r, xe_nxt;
  logic [7:0]    xo_r, xo_nxt;

  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] next_w;
  logic [CMPW-1:0] len_w;
  logic [CMPW-1:0] idx_w;
  logic [7:0]      len_cur;
  logic [7:0]      xe_cur;
  logic [7:0]      xo_cur;
  logic [7:0]      b;

  // per-byte decode
  always_comb begin
    b             = item.rx_byte;
    in_frame_nxt  = in_frame_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    xe_nxt        = xe_r;
    xo_nxt        = xo_r;
    has_result    = 1'b0;
    result        = '0;
    pos_w         = CMPW'(count_r);
    next_w        = pos_w + CMPW'(1);
    xe_cur        = pos_w[0] ? xe_r : (xe_r ^ b);
    xo_cur        = pos_w[0] ? (xo_r ^ b) : xo_r;
    len_cur       = (pos_w == CMPW'(brd_pkg::LEN_POS)) ? b : len_r;
    len_w         = CMPW'(len_cur);
    idx_w         = pos_w - CMPW'(brd_pkg::PAYLOAD_POS);

    if (item.restart || !in_frame_r) begin
      // first byte of a reply
      in_frame_nxt = 1'b0;
      count_nxt    = '0;
      len_nxt      = '0;
      xe_nxt       = brd_pkg::FOLD_INIT;
      xo_nxt       = brd_pkg::FOLD_INIT;
      unique case (b)
        brd_pkg::HDR_ACK: begin
          has_result         = 1'b1;
          result.result_kind = brd_pkg::KIND_STATUS;
          result.status      = brd_pkg::ST_ACK;
        end
        brd_pkg::HDR_NAK: begin
          has_result         = 1'b1;
          result.result_kind = brd_pkg::KIND_STATUS;
          result.status      = brd_pkg::ST_NAK;
        end
        brd_pkg::HDR_DATA: begin
          in_frame_nxt = 1'b1;
          count_nxt    = CW'(1);
          xe_nxt       = brd_pkg::FOLD_INIT ^ b;
        end
        default: begin
          has_result         = 1'b1;
          result.result_kind = brd_pkg::KIND_STATUS;
          result.data_byte   = b;
          result.status      = brd_pkg::ST_UNKNOWN;
        end
      endcase
    end else if (next_w >= CMPW'(brd_pkg::FRAME_EXTRA)
                 && next_w == len_w + CMPW'(brd_pkg::FRAME_EXTRA)) begin
      // frame complete, check both folds
      has_result         = 1'b1;
      result.result_kind = brd_pkg::KIND_STATUS;
      result.status      = (xe_cur == 8'h00 && xo_cur == 8'h00) ?
                           brd_pkg::ST_OK : brd_pkg::ST_CKSUM;
      in_frame_nxt       = 1'b0;
      count_nxt          = '0;
      len_nxt            = '0;
      xe_nxt             = brd_pkg::FOLD_INIT;
      xo_nxt             = brd_pkg::FOLD_INIT;
    end else if (next_w >= CMPW'(BUFFER_BYTES)) begin
      // buffer filled before frame end
      has_result         = 1'b1;
      result.result_kind = brd_pkg::KIND_STATUS;
      result.status      = brd_pkg::ST_OVERFLOW;
      in_frame_nxt       = 1'b0;
      count_nxt          = '0;
      len_nxt            = '0;
      xe_nxt             = brd_pkg::FOLD_INIT;
      xo_nxt             = brd_pkg::FOLD_INIT;
    end else begin
      // mid-frame byte, payload goes out as it arrives
      count_nxt = next_w[CW-1:0];
      len_nxt   = len_cur;
      xe_nxt    = xe_cur;
      xo_nxt    = xo_cur;
      if (pos_w >= CMPW'(brd_pkg::PAYLOAD_POS)
          && pos_w < len_w + CMPW'(brd_pkg::PAYLOAD_POS)) begin
        has_result           = 1'b1;
        result.result_kind   = brd_pkg::KIND_PAYLOAD;
        result.data_byte     = b;
        result.payload_index = idx_w[7:0];
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      len_r      <= '0;
      xe_r       <= brd_pkg::FOLD_INIT;
      xo_r       <= brd_pkg::FOLD_INIT;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      xe_r       <= xe_nxt;
      xo_r       <= xo_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/bootloader_reply_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bootloader_reply_deframer
// Recognizes bootloader replies in a received byte stream and emits payload
// bytes and a final reply status.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and gives at most one result per byte:
// each payload byte of a data frame with its index, and one status beat when
// a reply ends (ack, frame ok, nak, unknown type, checksum error, overflow).
// Payload beats go out before the frame is checked; drop them when the
// closing status is a checksum error. A byte passes from the input register to
// the result register, so the block sustains one byte per cycle; the only
// stall comes from a held result register when a byte produces a result.
module bootloader_reply_deframer #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire brd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output brd_pkg::out_item_t      out_data
);

  logic               stg_v_r;
  brd_pkg::in_item_t  stg_r;
  logic               out_v_r;
  brd_pkg::out_item_t out_r;
  logic               has_result;
  brd_pkg::out_item_t result;
  logic               out_free;
  logic               adv;

  brd_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (stg_r),
    .fire       (adv),
    .has_result (has_result),
    .result     (result)
  );

  // staged byte moves on when its result has room
  assign out_free = !out_v_r || out_ready;
  assign adv      = stg_v_r && (!has_result || out_free);
  assign in_ready = !stg_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_v_r <= 1'b1;
    end else if (adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && has_result) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: sv/brd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brd_checker
// Port-level checks on the result channel of the bootloader reply deframer.
// ----------------------------------------------------------------------------
module brd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire brd_pkg::out_item_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // payload beats carry no status code
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == brd_pkg::KIND_PAYLOAD
    |-> out_data.status == brd_pkg::ST_ACK)
    else $error("payload beat with nonzero status");

  // status beats carry a defined code and no index
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == brd_pkg::KIND_STATUS
    |-> out_data.payload_index == 8'h00
        && out_data.status <= brd_pkg::ST_OVERFLOW)
    else $error("status beat malformed");

  // only an unknown type reports its header byte
  a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == brd_pkg::KIND_STATUS
    && out_data.status != brd_pkg::ST_UNKNOWN |-> out_data.data_byte == 8'h00)
    else $error("status beat with stray data byte");

endmodule

bind bootloader_reply_deframer brd_checker u_brd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/tb_bootloader_reply_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bootloader_reply_deframer
// Self-checking bench for the bootloader reply deframer. Received bytes are
// driven through a queue-fed driver. Every accepted beat goes into a cycle-free
// model of the reply parser, which holds the expected payload and status
// beats. A monitor compares each result beat field by field with the oldest
// expectation. Stimulus is a short directed set of replies, then random well
// formed frames mixed with acks, naks, unknown headers, corrupted and cut
// frames, and noise, over three phases of input and output idling.
// ----------------------------------------------------------------------------
module tb_bootloader_reply_deframer;

  localparam int unsigned BUF_BYTES   = 256;
  localparam int unsigned SETTLE_CYC  = 20;
  localparam int unsigned RUN_LIMIT   = 300000;
  localparam int unsigned PHASE_BEATS = 450;
  localparam int unsigned REPORT_MAX  = 10;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  brd_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  brd_pkg::out_item_t out_data;

  // received bytes waiting to be offered, and reply beats still owed by the block
  brd_pkg::in_item_t  pending_bytes [$];
  brd_pkg::out_item_t expected_replies [$];

  int unsigned queued_beats   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned in_idle_pct    = 0;
  int unsigned out_idle_pct   = 0;
  int unsigned out_hold_cycles = 0;
  bit          offer_pending  = 1'b0;

  // parser model state
  bit          rx_in_frame;
  int unsigned rx_count;
  logic [7:0]  rx_len;
  logic [7:0]  rx_fold_even;
  logic [7:0]  rx_fold_odd;

  bootloader_reply_deframer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("bootloader_reply_deframer regression: fail");
      $finish;
    end
  end

  function automatic void clear_rx_state();
    rx_in_frame  = 1'b0;
    rx_count     = 0;
    rx_len       = 8'h00;
    rx_fold_even = brd_pkg::FOLD_INIT;
    rx_fold_odd  = brd_pkg::FOLD_INIT;
  endfunction

  // advance the parser by one byte and queue the beat it produces, if any
  function automatic void predict_reply(brd_pkg::in_item_t beat);
    brd_pkg::out_item_t res;
    bit          emits;
    int unsigned pos;
    int unsigned nxt;
    logic [7:0]  b;
    res   = '0;
    emits = 1'b0;
    b     = beat.rx_byte;
    if (beat.restart || !rx_in_frame) begin
      // first byte of a reply
      clear_rx_state();
      res.result_kind = brd_pkg::KIND_STATUS;
      emits = 1'b1;
      if (b == brd_pkg::HDR_ACK) begin
        res.status = brd_pkg::ST_ACK;
      end else if (b == brd_pkg::HDR_NAK) begin
        res.status = brd_pkg::ST_NAK;
      end else if (b != brd_pkg::HDR_DATA) begin
        res.status    = brd_pkg::ST_UNKNOWN;
        res.data_byte = b;
      end else begin
        rx_in_frame  = 1'b1;
        rx_fold_even = brd_pkg::FOLD_INIT ^ b;
        rx_count     = 1;
        if (rx_count >= BUF_BYTES) begin
          clear_rx_state();
          res.status = brd_pkg::ST_OVERFLOW;
        end else begin
          emits = 1'b0;
        end
      end
    end else begin
      // byte inside a data frame
      pos = rx_count;
      if (pos[0] == 1'b0) rx_fold_even = rx_fold_even ^ b;
      else rx_fold_odd = rx_fold_odd ^ b;
      if (pos == brd_pkg::LEN_POS) rx_len = b;
      nxt = pos + 1;
      if (nxt >= brd_pkg::FRAME_EXTRA
          && nxt == int'(rx_len) + brd_pkg::FRAME_EXTRA) begin
        res.result_kind = brd_pkg::KIND_STATUS;
        res.status = (rx_fold_even == 8'h00 && rx_fold_odd == 8'h00) ?
                     brd_pkg::ST_OK : brd_pkg::ST_CKSUM;
        emits = 1'b1;
        clear_rx_state();
      end else if (nxt >= BUF_BYTES) begin
        res.result_kind = brd_pkg::KIND_STATUS;
        res.status = brd_pkg::ST_OVERFLOW;
        emits = 1'b1;
        clear_rx_state();
      end else begin
        rx_count = nxt;
        if (pos >= brd_pkg::PAYLOAD_POS
            && pos < int'(rx_len) + brd_pkg::PAYLOAD_POS) begin
          res.result_kind   = brd_pkg::KIND_PAYLOAD;
          res.data_byte     = b;
          res.payload_index = 8'(pos - brd_pkg::PAYLOAD_POS);
          emits = 1'b1;
        end
      end
    end
    if (emits) expected_replies.push_back(res);
  endfunction

  // compare one result beat with the oldest expectation
  function automatic void check_result(brd_pkg::out_item_t got);
    brd_pkg::out_item_t want;
    if (expected_replies.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected result: kind %0d data %02h index %0d status %0d",
                 got.result_kind, got.data_byte, got.payload_index, got.status);
    end else begin
      want = expected_replies.pop_front();
      if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
          got.payload_index !== want.payload_index || got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display({"mismatch: expected kind %0d data %02h index %0d status %0d,",
                    " got kind %0d data %02h index %0d status %0d"},
                   want.result_kind, want.data_byte, want.payload_index, want.status,
                   got.result_kind, got.data_byte, got.payload_index, got.status);
      end
    end
  endfunction

  // driver: sample acceptance at the rising edge, present the next beat at the falling edge
  always begin : drive_input
    brd_pkg::in_item_t next_beat;
    @(posedge clk);
    if (rst_n && in_valid && in_ready) begin
      predict_reply(in_data);
      offer_pending = 1'b0;
    end
    @(negedge clk);
    if (!offer_pending) begin
      if (!rst_n || pending_bytes.size() == 0 || $urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        next_beat     = pending_bytes.pop_front();
        in_data       <= next_beat;
        in_valid      <= 1'b1;
        offer_pending = 1'b1;
      end
    end
  end

  // monitor: check at the rising edge, set ready at the falling edge
  always begin : watch_output
    @(posedge clk);
    if (rst_n && out_valid && out_ready) check_result(out_data);
    @(negedge clk);
    if (out_hold_cycles > 0) begin
      out_hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input bit restart);
    brd_pkg::in_item_t beat;
    beat.rx_byte = b;
    beat.restart = restart;
    pending_bytes.push_back(beat);
    queued_beats++;
  endtask

  // data frame with valid folds; optionally one byte flipped or the frame cut short
  task automatic queue_data_frame(input int unsigned len, input bit corrupt,
                                  input bit cut_short, input bit restart_first);
    logic [7:0]  frame [$];
    logic [7:0]  fold_even;
    logic [7:0]  fold_odd;
    logic [7:0]  b;
    int unsigned total;
    int unsigned keep;
    int unsigned k;
    total     = len + brd_pkg::FRAME_EXTRA;
    fold_even = brd_pkg::FOLD_INIT;
    fold_odd  = brd_pkg::FOLD_INIT;
    for (k = 0; k < len + brd_pkg::PAYLOAD_POS; k++) begin
      if (k == 0) b = brd_pkg::HDR_DATA;
      else if (k == brd_pkg::LEN_POS) b = 8'(len);
      else b = 8'($urandom_range(255));
      frame.push_back(b);
      if (k % 2 == 0) fold_even = fold_even ^ b;
      else fold_odd = fold_odd ^ b;
    end
    // the two closing bytes zero both folds
    if ((len + brd_pkg::PAYLOAD_POS) % 2 == 0) begin
      frame.push_back(fold_even);
      frame.push_back(fold_odd);
    end else begin
      frame.push_back(fold_odd);
      frame.push_back(fold_even);
    end
    if (corrupt) begin
      k = $urandom_range(total - 1, 1);
      if (k == brd_pkg::LEN_POS) k = 3;
      frame[k] = frame[k] ^ 8'(1 << $urandom_range(7));
    end
    keep = cut_short ? $urandom_range(total - 1, 1) : total;
    for (k = 0; k < keep; k++)
      queue_byte(frame[k], (k == 0) ? restart_first : 1'b0);
  endtask

  // mostly well formed replies with random content, some broken ones and noise
  task automatic queue_random_replies(input int unsigned budget, input int unsigned big_len);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    bit          resync;
    bit          rs;
    bit          cut;
    logic [7:0]  b;
    start  = queued_beats;
    resync = 1'b1;
    // one frame near the buffer size
    queue_data_frame(big_len, 1'b0, 1'b0, 1'b1);
    while (queued_beats - start < budget) begin
      pick   = $urandom_range(99);
      rs     = resync || ($urandom_range(3) == 0);
      resync = 1'b0;
      if (pick < 50) begin
        len = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(20);
        cut = ($urandom_range(9) == 0);
        queue_data_frame(len, $urandom_range(4) == 0, cut, rs);
        resync = cut;
      end else if (pick < 65) begin
        queue_byte(brd_pkg::HDR_ACK, rs);
      end else if (pick < 75) begin
        queue_byte(brd_pkg::HDR_NAK, rs);
      end else if (pick < 90) begin
        b = 8'($urandom_range(255));
        if (b == brd_pkg::HDR_DATA) b = b ^ 8'h01;
        queue_byte(b, rs);
      end else begin
        // noise burst, possibly leaving a partial frame behind
        n = $urandom_range(8, 1);
        repeat (n) queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        resync = 1'b1;
      end
    end
  endtask

  // let the sender run dry and every owed beat come back
  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || offer_pending || expected_replies.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    clear_rx_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // sender idles more rarely than the receiver
    in_idle_pct  = 26;
    out_idle_pct = 76;

    // directed replies: each header kind, extremes, short frames, restart in a frame
    queue_byte(brd_pkg::HDR_ACK, 1'b0);
    queue_byte(brd_pkg::HDR_NAK, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_data_frame(0, 1'b0, 1'b0, 1'b0);
    queue_data_frame(1, 1'b1, 1'b0, 1'b1);
    queue_byte(brd_pkg::HDR_DATA, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(brd_pkg::HDR_ACK, 1'b1);
    queue_data_frame(2, 1'b0, 1'b0, 1'b0);

    // frame that ends exactly at the buffer size
    queue_random_replies(PHASE_BEATS, BUF_BYTES - brd_pkg::FRAME_EXTRA);
    wait_for_drain();

    // receiver idles more rarely than the sender; longest frame overflows
    in_idle_pct  = 76;
    out_idle_pct = 26;
    queue_random_replies(PHASE_BEATS, 255);
    wait_for_drain();

    // no idling; long receiver hold while the sender keeps offering,
    // overflow lands on a payload byte
    in_idle_pct     = 0;
    out_idle_pct    = 0;
    out_hold_cycles = 400;
    queue_random_replies(PHASE_BEATS, BUF_BYTES - 4);
    wait_for_drain();

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("bootloader_reply_deframer regression: pass");
    end else begin
      $display("bootloader_reply_deframer regression: fail");
    end
    $finish;
  end

endmodule
